>>> design/tmzi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmzi_pkg: shared types and constants
// Transaction payloads, vertex record, queue entry and divider stage record.
// ----------------------------------------------------------------------------
package tmzi_pkg;

    localparam int FRAC_W      = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = 3;
    localparam logic [FRAC_W-1:0] FRAC_HALF = 16'h8000;

    typedef struct packed {
        logic               command;
        logic [11:0]        vertex_index;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
        logic signed [15:0] field_value;
        logic               value_valid;
        logic [11:0]        corner_a;
        logic [11:0]        corner_b;
        logic [11:0]        corner_c;
    } item_t;

    typedef struct packed {
        logic [15:0]        segment_number;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] start_z;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic signed [15:0] end_z;
    } result_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] val;
        logic               ok;
    } vertex_t;

    // point source: crossing on an edge, or a stored corner
    typedef enum logic [2:0] {
        SEL_AB = 3'd0,
        SEL_AC = 3'd1,
        SEL_BC = 3'd2,
        SEL_A  = 3'd3,
        SEL_B  = 3'd4,
        SEL_C  = 3'd5
    } sel_t;

    typedef struct packed {
        vertex_t a;
        vertex_t b;
        vertex_t c;
        sel_t    s0;
        sel_t    s1;
    } tri_t;

    typedef struct packed {
        logic [16:0]       rem;
        logic [FRAC_W-1:0] quo;
        logic [15:0]       den;
        logic              mid;
    } div_t;

endpackage
`default_nettype wire

>>> design/tmzi_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmzi_front: vertex store and triangle classification
// Takes transactions, writes vertex loads, reads three corners per triangle
// and decides which two points form the segment.
// ----------------------------------------------------------------------------
module tmzi_front #(
    parameter int VERTEX_COUNT = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire tmzi_pkg::item_t                item,
    input  wire logic [tmzi_pkg::QCNT_W-1:0]    queue_level,
    output logic                                push,
    output tmzi_pkg::tri_t                      push_data
);

    localparam int DEPTH = (VERTEX_COUNT < 4096) ? VERTEX_COUNT : 4096;
    localparam int AW    = $clog2(DEPTH);

    tmzi_pkg::vertex_t mem_a [DEPTH];
    tmzi_pkg::vertex_t mem_b [DEPTH];
    tmzi_pkg::vertex_t mem_c [DEPTH];
    tmzi_pkg::vertex_t rd_a_reg, rd_b_reg, rd_c_reg;
    tmzi_pkg::vertex_t wr_v;

    logic s1_valid_reg, range_ok_reg;
    logic accept, load_we, tri_go, tri_range;
    logic [2:0] cr;
    logic za, zb, zc;
    logic emit;
    tmzi_pkg::sel_t s0, s1;

    function automatic logic is_pos(input logic signed [15:0] v);
        is_pos = !v[15] && (v != 16'sd0);
    endfunction

    function automatic logic opp(input logic signed [15:0] p, input logic signed [15:0] q);
        opp = (is_pos(p) && q[15]) || (p[15] && is_pos(q));
    endfunction

    assign item_stall = (32'(queue_level) + 32'(s1_valid_reg)) >= tmzi_pkg::QUEUE_DEPTH;
    assign accept     = item_valid && !item_stall;
    assign load_we    = accept && !item.command && (32'(item.vertex_index) < VERTEX_COUNT);
    assign tri_go     = accept && item.command;
    assign tri_range  = (32'(item.corner_a) < VERTEX_COUNT) &&
                        (32'(item.corner_b) < VERTEX_COUNT) &&
                        (32'(item.corner_c) < VERTEX_COUNT);

    always_comb
    begin
        wr_v.x   = item.coord_x;
        wr_v.y   = item.coord_y;
        wr_v.z   = item.coord_z;
        wr_v.val = item.field_value;
        wr_v.ok  = item.value_valid;
    end

    // three copies of the store, one read port each
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            mem_a[item.vertex_index[AW-1:0]] <= wr_v;
            mem_b[item.vertex_index[AW-1:0]] <= wr_v;
            mem_c[item.vertex_index[AW-1:0]] <= wr_v;
        end
        if (tri_go)
        begin
            rd_a_reg <= mem_a[item.corner_a[AW-1:0]];
            rd_b_reg <= mem_b[item.corner_b[AW-1:0]];
            rd_c_reg <= mem_c[item.corner_c[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            range_ok_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= tri_go;
            if (tri_go)
                range_ok_reg <= tri_range;
        end
    end

    always_comb
    begin
        cr[0] = opp(rd_a_reg.val, rd_b_reg.val);
        cr[1] = opp(rd_a_reg.val, rd_c_reg.val);
        cr[2] = opp(rd_b_reg.val, rd_c_reg.val);
        za    = rd_a_reg.val == 16'sd0;
        zb    = rd_b_reg.val == 16'sd0;
        zc    = rd_c_reg.val == 16'sd0;
        emit  = 1'b0;
        s0    = tmzi_pkg::SEL_AB;
        s1    = tmzi_pkg::SEL_AB;
        if (range_ok_reg && rd_a_reg.ok && rd_b_reg.ok && rd_c_reg.ok)
        begin
            if (cr[0] && cr[1])
            begin
                emit = 1'b1; s0 = tmzi_pkg::SEL_AB; s1 = tmzi_pkg::SEL_AC;
            end
            else if (cr[0] && cr[2])
            begin
                emit = 1'b1; s0 = tmzi_pkg::SEL_AB; s1 = tmzi_pkg::SEL_BC;
            end
            else if (cr[1] && cr[2])
            begin
                emit = 1'b1; s0 = tmzi_pkg::SEL_AC; s1 = tmzi_pkg::SEL_BC;
            end
            else if (cr != 3'b000)
            begin
                // single crossing closed by the first zero corner
                s0 = cr[0] ? tmzi_pkg::SEL_AB : (cr[1] ? tmzi_pkg::SEL_AC : tmzi_pkg::SEL_BC);
                emit = za || zb || zc;
                s1 = za ? tmzi_pkg::SEL_A : (zb ? tmzi_pkg::SEL_B : tmzi_pkg::SEL_C);
            end
            else if (za && zb)
            begin
                emit = 1'b1; s0 = tmzi_pkg::SEL_A; s1 = tmzi_pkg::SEL_B;
            end
            else if (za && zc)
            begin
                emit = 1'b1; s0 = tmzi_pkg::SEL_A; s1 = tmzi_pkg::SEL_C;
            end
            else if (zb && zc)
            begin
                emit = 1'b1; s0 = tmzi_pkg::SEL_B; s1 = tmzi_pkg::SEL_C;
            end
        end
    end

    assign push = s1_valid_reg && emit;

    always_comb
    begin
        push_data.a  = rd_a_reg;
        push_data.b  = rd_b_reg;
        push_data.c  = rd_c_reg;
        push_data.s0 = s0;
        push_data.s1 = s1;
    end

endmodule
`default_nettype wire

>>> design/tmzi_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmzi_queue: short queue between classification and arithmetic
// Holds classified triangles so either side can stall on its own.
// ----------------------------------------------------------------------------
module tmzi_queue (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire tmzi_pkg::tri_t                 push_data,
    input  wire logic                           pop,
    output tmzi_pkg::tri_t                      head,
    output logic                                not_empty,
    output logic [tmzi_pkg::QCNT_W-1:0]         level
);

    localparam int PW = $clog2(tmzi_pkg::QUEUE_DEPTH);

    tmzi_pkg::tri_t                 slot_reg [tmzi_pkg::QUEUE_DEPTH];
    logic [PW-1:0]                  wr_ptr_reg, rd_ptr_reg;
    logic [tmzi_pkg::QCNT_W-1:0]    level_reg, level_next;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
            level_next = level_reg + 1'b1;
        else if (pop && !push)
            level_next = level_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            level_reg <= level_next;
        end
    end

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = level_reg != '0;
    assign level     = level_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg == tmzi_pkg::QCNT_W'(tmzi_pkg::QUEUE_DEPTH)) |-> (!push || pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue pop while empty");
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= tmzi_pkg::QCNT_W'(tmzi_pkg::QUEUE_DEPTH))
        else $error("queue level out of range");
    a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (level_reg == $past(level_reg) + 1'b1))
        else $error("queue level did not follow push");

endmodule
`default_nettype wire

>>> design/tmzi_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmzi_back: crossing arithmetic and result register
// Sixteen-stage radix-2 divider per edge, multiply stage, point select.
// ----------------------------------------------------------------------------
module tmzi_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tmzi_pkg::tri_t     head,
    input  wire logic               not_empty,
    output logic                    pop,
    input  wire logic [15:0]        threshold,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output tmzi_pkg::result_t       result
);

    localparam int NSTG = tmzi_pkg::FRAC_W;

    logic advance;

    tmzi_pkg::tri_t item_reg  [NSTG+1];
    logic           valid_reg [NSTG+1];
    tmzi_pkg::div_t dv_reg    [NSTG+1][3];
    tmzi_pkg::div_t dv_init   [3];
    tmzi_pkg::div_t dv_step   [NSTG][3];

    tmzi_pkg::tri_t     mitem_reg;
    logic               mvalid_reg;
    logic signed [33:0] prod_reg [3][3];

    logic signed [15:0] cross_pt [3][3];
    logic signed [15:0] p0 [3];
    logic signed [15:0] p1 [3];

    logic               result_valid_reg;
    tmzi_pkg::result_t  result_reg;
    logic [15:0]        count_reg, count_next;

    function automatic tmzi_pkg::vertex_t edge_lo(input tmzi_pkg::tri_t t, input int e);
        edge_lo = (e == 2) ? t.b : t.a;
    endfunction

    function automatic tmzi_pkg::vertex_t edge_hi(input tmzi_pkg::tri_t t, input int e);
        edge_hi = (e == 0) ? t.b : t.c;
    endfunction

    function automatic logic signed [15:0] axis(input tmzi_pkg::vertex_t v, input int ax);
        axis = (ax == 0) ? v.x : ((ax == 1) ? v.y : v.z);
    endfunction

    function automatic logic signed [15:0] pick(input tmzi_pkg::sel_t s,
                                                input tmzi_pkg::tri_t t,
                                                input logic signed [15:0] c0,
                                                input logic signed [15:0] c1,
                                                input logic signed [15:0] c2,
                                                input int ax);
        case (s)
            tmzi_pkg::SEL_AB: pick = c0;
            tmzi_pkg::SEL_AC: pick = c1;
            tmzi_pkg::SEL_BC: pick = c2;
            tmzi_pkg::SEL_A:  pick = axis(t.a, ax);
            tmzi_pkg::SEL_B:  pick = axis(t.b, ax);
            tmzi_pkg::SEL_C:  pick = axis(t.c, ax);
            default:          pick = c0;
        endcase
    endfunction

    assign advance = !result_valid_reg || !result_stall;
    assign pop     = advance && not_empty;

    // divider set-up: remainder starts at |a|, divisor |a-b|
    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            tmzi_pkg::vertex_t  lo_v, hi_v;
            logic signed [17:0] a18, b18, d18;
            logic [17:0]        na, nd;
            lo_v = edge_lo(head, e);
            hi_v = edge_hi(head, e);
            a18 = 18'(lo_v.val);
            b18 = 18'(hi_v.val);
            d18 = a18 - b18;
            na  = a18[17] ? 18'(-a18) : a18;
            nd  = d18[17] ? 18'(-d18) : d18;
            dv_init[e].rem = na[16:0];
            dv_init[e].quo = '0;
            dv_init[e].den = nd[15:0];
            dv_init[e].mid = (nd[15:0] < threshold) || (nd[15:0] == 16'd0);
        end
    end

    always_comb
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            for (int e = 0; e < 3; e++)
            begin
                logic [16:0] sh;
                sh = {dv_reg[k][e].rem[15:0], 1'b0};
                dv_step[k][e] = dv_reg[k][e];
                if (sh >= {1'b0, dv_reg[k][e].den})
                begin
                    dv_step[k][e].rem = sh - {1'b0, dv_reg[k][e].den};
                    dv_step[k][e].quo = {dv_reg[k][e].quo[NSTG-2:0], 1'b1};
                end
                else
                begin
                    dv_step[k][e].rem = sh;
                    dv_step[k][e].quo = {dv_reg[k][e].quo[NSTG-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg[0] <= head;
            for (int e = 0; e < 3; e++)
                dv_reg[0][e] <= dv_init[e];
            for (int k = 0; k < NSTG; k++)
            begin
                item_reg[k+1] <= item_reg[k];
                for (int e = 0; e < 3; e++)
                    dv_reg[k+1][e] <= dv_step[k][e];
            end
            mitem_reg <= item_reg[NSTG];
            for (int e = 0; e < 3; e++)
            begin
                for (int ax = 0; ax < 3; ax++)
                begin
                    logic [15:0]        f;
                    logic signed [16:0] diff;
                    f    = dv_reg[NSTG][e].mid ? tmzi_pkg::FRAC_HALF : dv_reg[NSTG][e].quo;
                    diff = 17'(axis(edge_hi(item_reg[NSTG], e), ax)) -
                           17'(axis(edge_lo(item_reg[NSTG], e), ax));
                    prod_reg[e][ax] <= $signed({1'b0, f}) * diff;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NSTG; k++)
                valid_reg[k] <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= not_empty;
            for (int k = 0; k < NSTG; k++)
                valid_reg[k+1] <= valid_reg[k];
            mvalid_reg <= valid_reg[NSTG];
        end
    end

    // floor of the product by 2^16 is its upper half
    always_comb
    begin
        for (int e = 0; e < 3; e++)
            for (int ax = 0; ax < 3; ax++)
                cross_pt[e][ax] = axis(edge_lo(mitem_reg, e), ax) + prod_reg[e][ax][31:16];
        for (int ax = 0; ax < 3; ax++)
        begin
            p0[ax] = pick(mitem_reg.s0, mitem_reg, cross_pt[0][ax], cross_pt[1][ax],
                          cross_pt[2][ax], ax);
            p1[ax] = pick(mitem_reg.s1, mitem_reg, cross_pt[0][ax], cross_pt[1][ax],
                          cross_pt[2][ax], ax);
        end
    end

    assign count_next = count_reg + 16'd1;

    always_ff @(posedge clk)
    begin
        if (advance && mvalid_reg)
        begin
            result_reg.segment_number <= count_next;
            result_reg.start_x        <= p0[0];
            result_reg.start_y        <= p0[1];
            result_reg.start_z        <= p0[2];
            result_reg.end_x          <= p1[0];
            result_reg.end_y          <= p1[1];
            result_reg.end_z          <= p1[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            count_reg        <= '0;
        end
        else if (advance)
        begin
            result_valid_reg <= mvalid_reg;
            if (mvalid_reg)
                count_reg <= count_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

>>> design/triangle_mesh_zero_isoline_core.sv
`default_nettype none
// Path from triangle acceptance to result valid: store read, queue, sixteen divider stages,
// multiply, output register; loads give no result.
// Throughput: one transaction per cycle while item_stall is low, set by the pipelined per-edge dividers.
// Reset: asynchronous, active low; clears control, segment count and threshold.
// The vertex store is not cleared; unwritten slots read undefined.
// ----------------------------------------------------------------------------
// triangle_mesh_zero_isoline_core: zero isoline extraction on a triangle mesh
// Front stores vertices and classifies triangles, back interpolates crossings.
// ----------------------------------------------------------------------------
module triangle_mesh_zero_isoline_core #(
    parameter int VERTEX_COUNT = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire tmzi_pkg::item_t    item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output tmzi_pkg::result_t       result,
    input  wire logic               cfg_write_en,
    input  wire logic [15:0]        cfg_write_data
);

    logic [15:0]                    threshold_reg;
    logic                           push, pop, not_empty;
    tmzi_pkg::tri_t                 push_data, head;
    logic [tmzi_pkg::QCNT_W-1:0]    level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= '0;
        else if (cfg_write_en)
            threshold_reg <= cfg_write_data;
    end

    tmzi_front #(.VERTEX_COUNT(VERTEX_COUNT)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .queue_level (level),
        .push        (push),
        .push_data   (push_data)
    );

    tmzi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .level     (level)
    );

    tmzi_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .not_empty    (not_empty),
        .pop          (pop),
        .threshold    (threshold_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire
